// ===== sv/mdls_pkg.sv =====
// package for the morse digit led sequencer
// types, register indexes, segment positions and the digit code table
// no dependencies
package mdls_pkg;

  typedef struct packed {
    logic       command;
    logic [7:0] character;
  } cmd_t;

  typedef struct packed {
    logic        led_on;
    logic [15:0] duration_ms;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [15:0] dot_ms;
    logic [15:0] dash_ms;
    logic [15:0] element_gap_ms;
    logic [15:0] letter_gap_ms;
    logic [15:0] word_gap_ms;
    logic [15:0] flutter_ms;
  } cfg_t;

  typedef enum logic [1:0] {
    KIND_OTHER,
    KIND_DIGIT,
    KIND_PERIOD,
    KIND_PREAMBLE
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [4:0] code;
  } desc_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } bk_state_t;

  localparam logic [2:0] REG_DOT_MS         = 3'd0;
  localparam logic [2:0] REG_DASH_MS        = 3'd1;
  localparam logic [2:0] REG_ELEMENT_GAP_MS = 3'd2;
  localparam logic [2:0] REG_LETTER_GAP_MS  = 3'd3;
  localparam logic [2:0] REG_WORD_GAP_MS    = 3'd4;
  localparam logic [2:0] REG_FLUTTER_MS     = 3'd5;

  localparam logic [15:0] RST_DOT_MS         = 16'd350;
  localparam logic [15:0] RST_DASH_MS        = 16'd1050;
  localparam logic [15:0] RST_ELEMENT_GAP_MS = 16'd350;
  localparam logic [15:0] RST_LETTER_GAP_MS  = 16'd1050;
  localparam logic [15:0] RST_WORD_GAP_MS    = 16'd2450;
  localparam logic [15:0] RST_FLUTTER_MS     = 16'd50;

  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_PERIOD = 8'h2E;

  localparam logic [3:0] SEG_OPEN          = 4'd0;
  localparam logic [3:0] SEG_LAST_PREAMBLE = 4'd10;
  localparam logic [3:0] SEG_LAST_DIGIT    = 4'd10;
  localparam logic [3:0] SEG_LAST_PERIOD   = 4'd11;

  // first element in bit 4, dash is 1
  function automatic logic [4:0] digit_code(input logic [3:0] digit);
    logic [4:0] code;
    case (digit)
      4'd0: code = 5'b11111;
      4'd1: code = 5'b01111;
      4'd2: code = 5'b00111;
      4'd3: code = 5'b00011;
      4'd4: code = 5'b00001;
      4'd5: code = 5'b00000;
      4'd6: code = 5'b10000;
      4'd7: code = 5'b11000;
      4'd8: code = 5'b11100;
      4'd9: code = 5'b11110;
      default: code = 5'b00000;
    endcase
    return code;
  endfunction

endpackage

// ===== sv/mdls_front.sv =====
// front end: accepts a command transfer and classifies it into a descriptor
// depends on mdls_pkg
module mdls_front (
  input  logic              start,
  input  logic              busy,
  input  mdls_pkg::cmd_t    item,
  output logic              push,
  output mdls_pkg::desc_t   desc
);

  logic [7:0] offset;

  assign push   = start & ~busy;
  assign offset = item.character - mdls_pkg::CHAR_ZERO;

  always_comb begin
    desc.code = 5'b00000;
    if (item.command) begin
      desc.kind = mdls_pkg::KIND_PREAMBLE;
    end else if (item.character == mdls_pkg::CHAR_PERIOD) begin
      desc.kind = mdls_pkg::KIND_PERIOD;
    end else if (item.character >= mdls_pkg::CHAR_ZERO &&
                 item.character <= mdls_pkg::CHAR_NINE) begin
      desc.kind = mdls_pkg::KIND_DIGIT;
      desc.code = mdls_pkg::digit_code(offset[3:0]);
    end else begin
      desc.kind = mdls_pkg::KIND_OTHER;
    end
  end

endmodule

// ===== sv/mdls_queue.sv =====
// descriptor queue between front end and sequencer
// depends on mdls_pkg
module mdls_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mdls_pkg::desc_t wr_data,
  input  logic            pop,
  output mdls_pkg::desc_t rd_data,
  output logic            full,
  output logic            empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mdls_pkg::desc_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
      (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not follow a write");
`endif

endmodule

// ===== sv/mdls_back.sv =====
// sequencer: turns one descriptor into its run of led segments, one per cycle
// depends on mdls_pkg
module mdls_back (
  input  logic              clk,
  input  logic              rst,
  input  mdls_pkg::cfg_t    cfg,
  input  mdls_pkg::desc_t   rd_data,
  input  logic              empty,
  output logic              pop,
  output logic              strobe,
  output mdls_pkg::result_t result
);

  mdls_pkg::bk_state_t state;
  mdls_pkg::bk_state_t state_next;
  mdls_pkg::desc_t     desc;
  mdls_pkg::desc_t     desc_next;
  logic [3:0]          seg;
  logic [3:0]          seg_next;
  mdls_pkg::result_t   seg_res;
  logic                seg_last;

  // segment at the current position
  always_comb begin
    seg_res = '0;
    case (desc.kind)
      mdls_pkg::KIND_PREAMBLE: begin
        if (seg == mdls_pkg::SEG_LAST_PREAMBLE) begin
          seg_res.duration_ms = cfg.word_gap_ms;
          seg_res.last        = 1'b1;
        end else begin
          seg_res.led_on      = ~seg[0];
          seg_res.duration_ms = cfg.flutter_ms;
        end
      end
      mdls_pkg::KIND_PERIOD: begin
        if (seg == mdls_pkg::SEG_OPEN) begin
          seg_res.duration_ms = cfg.letter_gap_ms;
        end else if (seg == mdls_pkg::SEG_LAST_PERIOD) begin
          seg_res.duration_ms = cfg.letter_gap_ms;
          seg_res.last        = 1'b1;
        end else begin
          seg_res.led_on      = seg[0];
          seg_res.duration_ms = cfg.flutter_ms;
        end
      end
      mdls_pkg::KIND_DIGIT: begin
        if (seg == mdls_pkg::SEG_OPEN) begin
          seg_res.duration_ms = cfg.letter_gap_ms;
        end else if (seg[0]) begin
          seg_res.led_on      = 1'b1;
          seg_res.duration_ms = desc.code[4] ? cfg.dash_ms : cfg.dot_ms;
        end else begin
          seg_res.duration_ms = cfg.element_gap_ms;
          seg_res.last        = (seg == mdls_pkg::SEG_LAST_DIGIT);
        end
      end
      default: begin
        seg_res.duration_ms = cfg.letter_gap_ms;
        seg_res.last        = 1'b1;
      end
    endcase
  end

  assign seg_last = seg_res.last;

  always_comb begin
    state_next = state;
    desc_next  = desc;
    seg_next   = seg;
    pop        = 1'b0;
    case (state)
      mdls_pkg::BK_IDLE: begin
        if (!empty) begin
          pop        = 1'b1;
          desc_next  = rd_data;
          seg_next   = mdls_pkg::SEG_OPEN;
          state_next = mdls_pkg::BK_RUN;
        end
      end
      mdls_pkg::BK_RUN: begin
        if (seg_last) begin
          if (!empty) begin
            pop       = 1'b1;
            desc_next = rd_data;
            seg_next  = mdls_pkg::SEG_OPEN;
          end else begin
            state_next = mdls_pkg::BK_IDLE;
          end
        end else begin
          seg_next = seg + 1'b1;
          // step to the next element after each lit digit segment
          if (desc.kind == mdls_pkg::KIND_DIGIT && seg[0]) begin
            desc_next.code = {desc.code[3:0], 1'b0};
          end
        end
      end
      default: begin
        state_next = mdls_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= mdls_pkg::BK_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= (state == mdls_pkg::BK_RUN);
    end
  end

  always_ff @(posedge clk) begin
    desc   <= desc_next;
    seg    <= seg_next;
    result <= seg_res;
  end

`ifndef SYNTH
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
      (state == mdls_pkg::BK_IDLE) |=> !strobe)
    else $error("result transfer without a running descriptor");
  a_pop_at_boundary: assert property (@(posedge clk) disable iff (rst)
      pop |-> ((state == mdls_pkg::BK_IDLE) || seg_last))
    else $error("descriptor taken in the middle of a run");
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
      ((state == mdls_pkg::BK_RUN) && seg_last && empty) |=> (state == mdls_pkg::BK_IDLE))
    else $error("sequencer kept running past the final segment");
`endif

endmodule

// ===== sv/morse_digit_led_sequencer.sv =====
// morse digit led sequencer, top level: register file, front end, queue, sequencer
// from idle, a start transfer is written to the queue, loaded into the sequencer, then registered onto result
// throughput: one segment a cycle; a run is 1 to 12 segments, back to back
// busy rises only while the descriptor queue is full; results cannot be stalled
// rst (synchronous) restores register defaults and empties queue and sequencer
// depends on mdls_pkg, mdls_front, mdls_queue, mdls_back
module morse_digit_led_sequencer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  mdls_pkg::cmd_t    item,
  output logic              strobe,
  output mdls_pkg::result_t result,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  mdls_pkg::cfg_t  cfg;
  mdls_pkg::desc_t wr_desc;
  mdls_pkg::desc_t rd_desc;
  logic            push;
  logic            pop;
  logic            full;
  logic            empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dot_ms         <= mdls_pkg::RST_DOT_MS;
      cfg.dash_ms        <= mdls_pkg::RST_DASH_MS;
      cfg.element_gap_ms <= mdls_pkg::RST_ELEMENT_GAP_MS;
      cfg.letter_gap_ms  <= mdls_pkg::RST_LETTER_GAP_MS;
      cfg.word_gap_ms    <= mdls_pkg::RST_WORD_GAP_MS;
      cfg.flutter_ms     <= mdls_pkg::RST_FLUTTER_MS;
    end else if (cfg_we) begin
      case (cfg_index)
        mdls_pkg::REG_DOT_MS:         cfg.dot_ms         <= cfg_data;
        mdls_pkg::REG_DASH_MS:        cfg.dash_ms        <= cfg_data;
        mdls_pkg::REG_ELEMENT_GAP_MS: cfg.element_gap_ms <= cfg_data;
        mdls_pkg::REG_LETTER_GAP_MS:  cfg.letter_gap_ms  <= cfg_data;
        mdls_pkg::REG_WORD_GAP_MS:    cfg.word_gap_ms    <= cfg_data;
        mdls_pkg::REG_FLUTTER_MS:     cfg.flutter_ms     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = full;

  mdls_front u_front (
    .start (start),
    .busy  (busy),
    .item  (item),
    .push  (push),
    .desc  (wr_desc)
  );

  mdls_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_desc),
    .pop     (pop),
    .rd_data (rd_desc),
    .full    (full),
    .empty   (empty)
  );

  mdls_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .rd_data (rd_desc),
    .empty   (empty),
    .pop     (pop),
    .strobe  (strobe),
    .result  (result)
  );

endmodule

// ===== sim/tb_top.sv =====
// testbench for morse_digit_led_sequencer: directed and random commands, own segment predictor
// checks every led segment against the predicted run; depends on mdls_pkg and the block's rtl
`timescale 1ns / 100ps

module tb_top;

  localparam int LIMIT_CYCLES = 200000;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_TAIL   = 4;
  localparam int TAPS         = 5;
  localparam int MORSE_LEN    = 5;
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  mdls_pkg::cmd_t    item = '0;
  logic              strobe;
  mdls_pkg::result_t result;
  logic              cfg_we = 1'b0;
  logic [2:0]        cfg_index = '0;
  logic [15:0]       cfg_data = '0;

  logic [15:0]       reg_file [mdls_pkg::REG_DOT_MS:mdls_pkg::REG_FLUTTER_MS];
  mdls_pkg::result_t segs_due [$];
  int                bad_segs = 0;
  int                cycles = 0;
  int                idle_pct = 0;
  bit                start_hi = 1'b0;

  morse_digit_led_sequencer i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .strobe    (strobe),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT_CYCLES) begin
      $display("run timed out after %0d cycles", cycles);
      $display("tb_top failed");
      $finish;
    end
  end

  // segment checker
  always @(posedge clk) begin : check_seg
    mdls_pkg::result_t want;
    if (!rst && strobe === 1'b1) begin
      if (segs_due.size() == 0) begin
        bad_segs++;
        if (bad_segs <= MAX_REPORTS)
          $display("unexpected segment: led_on=%0b duration_ms=%0d last=%0b",
                   result.led_on, result.duration_ms, result.last);
      end else begin
        want = segs_due.pop_front();
        if (result.led_on !== want.led_on || result.duration_ms !== want.duration_ms ||
            result.last !== want.last) begin
          bad_segs++;
          if (bad_segs <= MAX_REPORTS)
            $display({"segment mismatch: expected led_on=%0b duration_ms=%0d last=%0b,",
                      " got led_on=%0b duration_ms=%0d last=%0b"},
                     want.led_on, want.duration_ms, want.last,
                     result.led_on, result.duration_ms, result.last);
        end
      end
    end
  end

  task automatic push_seg(input logic level, input logic [15:0] ms);
    mdls_pkg::result_t s;
    s.led_on      = level;
    s.duration_ms = ms;
    s.last        = 1'b0;
    segs_due.push_back(s);
  endtask

  task automatic push_flutter();
    for (int t = 0; t < TAPS; t++) begin
      push_seg(1'b1, reg_file[mdls_pkg::REG_FLUTTER_MS]);
      push_seg(1'b0, reg_file[mdls_pkg::REG_FLUTTER_MS]);
    end
  endtask

  task automatic predict_run(input mdls_pkg::cmd_t c);
    mdls_pkg::result_t tail;
    int                d;
    logic              dash;
    if (c.command) begin
      push_flutter();
      push_seg(1'b0, reg_file[mdls_pkg::REG_WORD_GAP_MS]);
    end else begin
      push_seg(1'b0, reg_file[mdls_pkg::REG_LETTER_GAP_MS]);
      if (c.character == mdls_pkg::CHAR_PERIOD) begin
        push_flutter();
        push_seg(1'b0, reg_file[mdls_pkg::REG_LETTER_GAP_MS]);
      end else if (c.character >= mdls_pkg::CHAR_ZERO &&
                   c.character <= mdls_pkg::CHAR_NINE) begin
        d = c.character - mdls_pkg::CHAR_ZERO;
        // digits one to five open with dots, zero and the rest open with dashes
        for (int k = 0; k < MORSE_LEN; k++) begin
          dash = (d <= MORSE_LEN) ? (k >= d) : (k < d - MORSE_LEN);
          push_seg(1'b1, dash ? reg_file[mdls_pkg::REG_DASH_MS]
                              : reg_file[mdls_pkg::REG_DOT_MS]);
          push_seg(1'b0, reg_file[mdls_pkg::REG_ELEMENT_GAP_MS]);
        end
      end
    end
    tail = segs_due.pop_back();
    tail.last = 1'b1;
    segs_due.push_back(tail);
  endtask

  task automatic drive_start(input bit level);
    if (start_hi != level) begin
      start    <= level;
      start_hi = level;
    end
  endtask

  function automatic int pick_gap();
    int n;
    n = 0;
    while (n < 200 && $urandom_range(99) < idle_pct)
      n++;
    return n;
  endfunction

  // one command transfer, then an optional idle gap
  task automatic send_one(input mdls_pkg::cmd_t c);
    int gap;
    item <= c;
    drive_start(1'b1);
    do @(posedge clk); while (busy !== 1'b0);
    predict_run(c);
    gap = pick_gap();
    if (gap > 0) begin
      drive_start(1'b0);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_char(input logic [7:0] ch);
    mdls_pkg::cmd_t c;
    c.command   = 1'b0;
    c.character = ch;
    send_one(c);
  endtask

  task automatic send_preamble(input logic [7:0] ch);
    mdls_pkg::cmd_t c;
    c.command   = 1'b1;
    c.character = ch;
    send_one(c);
  endtask

  task automatic wait_drained();
    drive_start(1'b0);
    while (segs_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx <= mdls_pkg::REG_FLUTTER_MS)
      reg_file[idx] = val;
  endtask

  task automatic load_config(input logic [15:0] dot, input logic [15:0] dash,
                             input logic [15:0] egap, input logic [15:0] lgap,
                             input logic [15:0] wgap, input logic [15:0] flut);
    write_reg(mdls_pkg::REG_DOT_MS, dot);
    write_reg(REG_SPARE_LO, 16'($urandom_range(16'hFFFF)));
    write_reg(mdls_pkg::REG_DASH_MS, dash);
    write_reg(mdls_pkg::REG_ELEMENT_GAP_MS, egap);
    write_reg(mdls_pkg::REG_LETTER_GAP_MS, lgap);
    write_reg(mdls_pkg::REG_WORD_GAP_MS, wgap);
    write_reg(mdls_pkg::REG_FLUTTER_MS, flut);
    write_reg(REG_SPARE_HI, 16'($urandom_range(16'hFFFF)));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_ms();
    int r;
    r = $urandom_range(9);
    if (r == 0)
      return 16'd1;
    else if (r == 1)
      return 16'hFFFF;
    return 16'($urandom_range(1, 16'hFFFF));
  endfunction

  function automatic mdls_pkg::cmd_t pick_cmd();
    mdls_pkg::cmd_t c;
    int             r;
    r = $urandom_range(19);
    c.command   = 1'b0;
    c.character = 8'($urandom_range(255));
    if (r < 9)
      c.character = 8'(mdls_pkg::CHAR_ZERO + $urandom_range(9));
    else if (r < 12)
      c.character = mdls_pkg::CHAR_PERIOD;
    else if (r < 15)
      c.command = 1'b1;
    return c;
  endfunction

  task automatic test_reset_defaults();
    idle_pct = 0;
    for (int d = 0; d <= 9; d++)
      send_char(8'(mdls_pkg::CHAR_ZERO + d));
    send_char(mdls_pkg::CHAR_PERIOD);
    send_preamble(8'hFF);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(8'(mdls_pkg::CHAR_ZERO - 1));
    send_char(8'(mdls_pkg::CHAR_NINE + 1));
    wait_drained();
  endtask

  task automatic test_register_extremes();
    idle_pct = 15;
    load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_preamble(8'h00);
    send_char(8'(mdls_pkg::CHAR_ZERO + 7));
    send_char(mdls_pkg::CHAR_PERIOD);
    wait_drained();
    // zero durations pass straight through
    load_config('0, '0, '0, '0, '0, '0);
    send_preamble(8'h00);
    send_char(8'(mdls_pkg::CHAR_ZERO + 7));
    send_char(mdls_pkg::CHAR_PERIOD);
    wait_drained();
    load_config(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
    send_preamble(8'h00);
    send_char(8'(mdls_pkg::CHAR_ZERO + 7));
    send_char(mdls_pkg::CHAR_PERIOD);
    wait_drained();
  endtask

  task automatic run_phase(input int pct, input int count);
    idle_pct = pct;
    load_config(pick_ms(), pick_ms(), pick_ms(), pick_ms(), pick_ms(), pick_ms());
    for (int n = 0; n < count; n++) begin
      send_one(pick_cmd());
      if ($urandom_range(19) == 0)
        wait_drained();
    end
    wait_drained();
  endtask

  task automatic test_random_traffic();
    run_phase(0, 45);
    run_phase(80, 45);
    run_phase(15, 45);
    run_phase(0, 40);
    run_phase(80, 40);
    run_phase(15, 40);
  endtask

  initial begin
    reg_file[mdls_pkg::REG_DOT_MS]         = mdls_pkg::RST_DOT_MS;
    reg_file[mdls_pkg::REG_DASH_MS]        = mdls_pkg::RST_DASH_MS;
    reg_file[mdls_pkg::REG_ELEMENT_GAP_MS] = mdls_pkg::RST_ELEMENT_GAP_MS;
    reg_file[mdls_pkg::REG_LETTER_GAP_MS]  = mdls_pkg::RST_LETTER_GAP_MS;
    reg_file[mdls_pkg::REG_WORD_GAP_MS]    = mdls_pkg::RST_WORD_GAP_MS;
    reg_file[mdls_pkg::REG_FLUTTER_MS]     = mdls_pkg::RST_FLUTTER_MS;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_register_extremes();
    test_random_traffic();

    if (segs_due.size() != 0) begin
      bad_segs += segs_due.size();
      $display("%0d segments never arrived", segs_due.size());
    end
    if (bad_segs == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule
